// File: hw/rtl/tma_pkg.sv
// Shared types and constants for the trimmed mean ADC averager.
`default_nettype none

package tma_pkg;

    localparam int MAX_CHANNELS = 6;
    localparam int FIELD_BITS = 12;
    localparam int SUM_BITS = 16;
    localparam int COUNT_BITS = 4;
    localparam int TRIM_SHIFT = 3;
    localparam int WINDOW_ITEMS = 10;

    localparam int DEF_NUM_CHANNELS = 6;
    localparam int DEF_SAMPLE_BITS = 12;

    typedef logic [FIELD_BITS-1:0] t_field;
    typedef logic [SUM_BITS-1:0] t_sum;
    typedef logic [COUNT_BITS-1:0] t_count;

    localparam t_count LAST_COUNT = t_count'(WINDOW_ITEMS - 1);

    typedef struct packed {
        t_field sample_ch5;
        t_field sample_ch4;
        t_field sample_ch3;
        t_field sample_ch2;
        t_field sample_ch1;
        t_field sample_ch0;
    } t_in_word;

    typedef struct packed {
        t_field avg_ch5;
        t_field avg_ch4;
        t_field avg_ch3;
        t_field avg_ch2;
        t_field avg_ch1;
        t_field avg_ch0;
    } t_out_word;

    typedef struct packed {
        logic accept;
        logic last;
    } t_lane_ctrl;

endpackage

`default_nettype wire

// File: hw/rtl/tma_stream_if.sv
// Valid and ready stream interface that carries one word per handshake.
`default_nettype none

interface tma_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/trimmed_mean_adc_averager_unit.sv
// Top level of the trimmed mean averager: item counter, channel lanes and merging stage.
//
// Channel  Direction  Word                                    Per handshake
// i_in     sink       sample_ch0 .. sample_ch5, 12 bits each  one item, all channels
// o_out    source     avg_ch0 .. avg_ch5, 12 bits each        one result per ten items
//
// The block takes one item per cycle while input ready is high; the lanes update in the accepting cycle.
// The result of the tenth item enters the output register at that edge.
// Reset clears the sums, maxima and item count, sets the minima to all ones, and empties the output.
// Input ready drops only while a result waits in the output register and the sink stalls.
`default_nettype none

module trimmed_mean_adc_averager_unit #(
    parameter int NUM_CHANNELS = tma_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS = tma_pkg::DEF_SAMPLE_BITS
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    tma_stream_if.sink i_in,
    tma_stream_if.source o_out
);

    tma_pkg::t_count     r_count, n_count;
    tma_pkg::t_lane_ctrl w_ctrl;
    tma_pkg::t_in_word   w_word;
    tma_pkg::t_field     w_sample [tma_pkg::MAX_CHANNELS];
    tma_pkg::t_field     w_avg [tma_pkg::MAX_CHANNELS];

    assign i_in.ready = !o_out.valid || o_out.ready;

    always_comb begin
        w_word        = i_in.data;
        w_ctrl.accept = i_in.valid && i_in.ready;
        w_ctrl.last   = (r_count >= tma_pkg::LAST_COUNT);
        w_sample[0]   = w_word.sample_ch0;
        w_sample[1]   = w_word.sample_ch1;
        w_sample[2]   = w_word.sample_ch2;
        w_sample[3]   = w_word.sample_ch3;
        w_sample[4]   = w_word.sample_ch4;
        w_sample[5]   = w_word.sample_ch5;

        n_count = r_count;
        if (w_ctrl.accept) begin
            n_count = w_ctrl.last ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar c = 0; c < tma_pkg::MAX_CHANNELS; c++) begin : g_lane
        if (c < NUM_CHANNELS) begin : g_used
            tma_lane #(
                .SAMPLE_BITS(SAMPLE_BITS)
            ) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_sample(w_sample[c]),
                .o_avg   (w_avg[c])
            );
        end else begin : g_unused
            assign w_avg[c] = '0;
        end
    end

    tma_merge u_merge (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_ctrl.accept && w_ctrl.last),
        .i_avg  (w_avg),
        .o_out  (o_out)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tma_pkg::LAST_COUNT)
        else $error("Item count left the window range.");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.accept && w_ctrl.last) |=> o_out.valid)
        else $error("Tenth item did not produce a result.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.accept && !w_ctrl.last) |=> (r_count == $past(r_count) + 1'b1))
        else $error("Item count did not advance on an accepted item.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out.valid && !(w_ctrl.accept && w_ctrl.last)) |=> !o_out.valid)
        else $error("Result appeared without a completed window.");

endmodule

`default_nettype wire

// File: hw/rtl/tma_lane.sv
// One channel lane: running sum, maximum and minimum, and the trimmed mean.
`default_nettype none

module tma_lane #(
    parameter int SAMPLE_BITS = tma_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tma_pkg::t_lane_ctrl i_ctrl,
    input  wire tma_pkg::t_field     i_sample,
    output tma_pkg::t_field          o_avg
);

    logic [SAMPLE_BITS-1:0] r_max, n_max, w_max;
    logic [SAMPLE_BITS-1:0] r_min, n_min, w_min;
    tma_pkg::t_sum          r_sum, n_sum, w_sum;
    logic [SAMPLE_BITS-1:0] w_s;
    tma_pkg::t_sum          w_diff;

    always_comb begin
        w_s    = i_sample[SAMPLE_BITS-1:0];
        w_max  = (w_s > r_max) ? w_s : r_max;
        w_min  = (w_s < r_min) ? w_s : r_min;
        w_sum  = r_sum + tma_pkg::t_sum'(w_s);
        w_diff = w_sum - tma_pkg::t_sum'(w_max) - tma_pkg::t_sum'(w_min);
        o_avg  = w_diff[tma_pkg::TRIM_SHIFT +: tma_pkg::FIELD_BITS];

        n_max = r_max;
        n_min = r_min;
        n_sum = r_sum;
        if (i_ctrl.accept) begin
            if (i_ctrl.last) begin
                n_max = '0;
                n_min = '1;
                n_sum = '0;
            end else begin
                n_max = w_max;
                n_min = w_min;
                n_sum = w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_min <= '1;
            r_sum <= '0;
        end else begin
            r_max <= n_max;
            r_min <= n_min;
            r_sum <= n_sum;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tma_merge.sv
// Merging stage that collects the lane averages into the output register.
`default_nettype none

module tma_merge (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire tma_pkg::t_field i_avg [tma_pkg::MAX_CHANNELS],
    tma_stream_if.source         o_out
);

    logic               r_valid, n_valid;
    tma_pkg::t_out_word r_data, n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_load) begin
            n_valid        = 1'b1;
            n_data.avg_ch0 = i_avg[0];
            n_data.avg_ch1 = i_avg[1];
            n_data.avg_ch2 = i_avg[2];
            n_data.avg_ch3 = i_avg[3];
            n_data.avg_ch4 = i_avg[4];
            n_data.avg_ch5 = i_avg[5];
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule

`default_nettype wire
